### design/ttg_pkg.sv
// shared constants, types and sine table builder for the three-tone generator
package ttg_pkg;

  localparam int unsigned SINE_ENTRIES = 1024;
  localparam int unsigned SINE_AW      = $clog2(SINE_ENTRIES);

  localparam int unsigned SR_W       = 18;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned FREQ_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 24;

  localparam int unsigned DIV_W  = 40;
  localparam int unsigned REM_W  = 24;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_THREE  = 3'd4;

  localparam logic [LEN_W-1:0]    LEN_MAX  = '1;
  localparam logic [16:0]         FADE_ONE = 17'h10000;
  localparam logic [SAMPLE_W-1:0] PEAK     = 16'd32767;

  typedef logic [15:0] sine_rom_t [SINE_ENTRIES];

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_MUL, S_LEN_GO, S_LEN_WT, S_FL_GO, S_FL_WT, S_CHECK,
    S_RES_GO, S_RES_WT, S_FRQ_GO, S_FRQ_WT, S_PH_GO, S_PH_WT, S_ROM, S_ACC,
    S_FADE_GO, S_FADE_WT, S_MUL, S_FIN_GO, S_FIN_WT, S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [REM_W-1:0]  divisor;
    logic [REM_W-1:0]  rem_init;
    logic [DIV_W-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // shift-subtract quotient for building the table
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // quarter-wave sine in q15 from an integer taylor series on a q30 angle
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] dv;
    logic [63:0] q;
    longint      sum;
    logic        neg;
    x    = (64'd1686629713 * 64'(k)) >> SINE_AW;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    neg  = 1'b1;
    for (int unsigned n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        dv   = 64'((2 * n) * (2 * n + 1));
        term = udiv64((term * x2) >> 30, dv);
        sum  = neg ? sum - longint'(term) : sum + longint'(term);
        neg  = !neg;
      end
    end
    if (sum < 0) sum = 0;
    q = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t t;
    for (int unsigned k = 0; k < SINE_ENTRIES; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

endpackage

### design/ttg_serial_div.sv
// restoring divider, one quotient bit per cycle
module ttg_serial_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ttg_pkg::div_req_t           req_i,
  output ttg_pkg::div_stat_t          stat_o,
  output logic [ttg_pkg::DIV_W-1:0]   quo_o,
  output logic [ttg_pkg::REM_W-1:0]   rem_o
);
  import ttg_pkg::*;

  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  quo_r;
  logic [REM_W-1:0]  divisor_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    rem_dif;
  logic              ge;

  // shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign rem_dif = rem_sh - {1'b0, divisor_r};
  assign ge      = rem_sh >= {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req_i.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      rem_r     <= req_i.rem_init;
      dvd_r     <= req_i.dividend;
      quo_r     <= '0;
      divisor_r <= req_i.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_dif[REM_W-1:0] : rem_sh[REM_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_r;
  assign stat_o.done = done_r;
  assign quo_o       = quo_r;
  assign rem_o       = rem_r;

endmodule

### design/ttg_sine_rom.sv
// quarter-wave sine rom with registered read
module ttg_sine_rom (
  input  logic                        clk,
  input  logic [ttg_pkg::SINE_AW-1:0] addr_i,
  output logic [15:0]                 data_o
);
  import ttg_pkg::*;

  localparam sine_rom_t ROM = build_sine_rom();

  logic [15:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= ROM[addr_i];
  end

  assign data_o = data_r;

endmodule

### design/three_tone_generator_with_fade_core.sv
// top level of the three-tone sine generator with linear fade
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | in        | in_valid / in_ready  | in_restart
//   out     | out       | out_valid / out_ready| out_sample, out_last
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one beat at a time: each sample or restart beat is worked to its end before the
//   next acceptance; a restart beat first runs the length and fade divisions
//   the shared bit-serial divider (one quotient bit per cycle) runs three divisions
//   per tone, the fade division while the fade ramps, and the averaging division
// reset (synchronous, rst_n low) loads the default settings and ends any tone
// a finished sample sits in the output register; a new input beat is taken
//   while it waits, and the next result waits for it to drain
// cfg_ready is always high; writes belong in idle time
module three_tone_generator_with_fade_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_restart,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ttg_pkg::SAMPLE_W-1:0] out_sample,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ttg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ttg_pkg::*;

  // settings
  logic [SR_W-1:0]   sample_rate_r;
  logic [DUR_W-1:0]  duration_ms_r;
  logic [FREQ_W-1:0] tone_one_hz_r;
  logic [FREQ_W-1:0] tone_two_hz_r;
  logic [FREQ_W-1:0] tone_three_hz_r;

  // tone state
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  sample_index_r;
  logic [LEN_W-1:0]  tone_length_r;
  logic [LEN_W-1:0]  fade_length_r;
  logic [SR_W-1:0]   residue_r [3];

  // per-sample working registers
  logic [1:0]        tone_r;
  logic signed [17:0] sum_r;
  logic [SR_W-1:0]   r_r;
  logic [SR_W-1:0]   fm_r;
  logic [15:0]       phase_r;
  logic [16:0]       fade_r;
  logic [33:0]       prod_r;
  logic [33:0]       prod_len_r;
  logic              neg_r;
  logic signed [SAMPLE_W-1:0] sample_res_r;

  // output register
  logic              out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic              out_last_r;

  // divider and rom
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DIV_W-1:0]  div_quo;
  logic [REM_W-1:0]  div_rem;
  logic [SINE_AW-1:0] rom_addr;
  logic [15:0]       rom_data;

  // combinational helpers
  logic              in_acc;
  logic              settings_ok;
  logic [FREQ_W-1:0] freq_sel;
  logic              tone_active;
  logic [1:0]        tone_count;
  logic              fade_in, fade_out, fade_div_en;
  logic [LEN_W-1:0]  fade_num;
  logic [SR_W:0]     res_sum;
  logic [SR_W-1:0]   res_nxt;
  logic [SINE_AW+17:0] pos_full;
  logic [SINE_AW+1:0]  pos;
  logic [SINE_AW-1:0]  pos_k;
  logic [SAMPLE_W-1:0] wave_mag;
  logic signed [17:0]  wave_val;
  logic [17:0]       sum_abs;
  logic [15:0]       mag_sat;
  logic              out_go;

  ttg_serial_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  ttg_sine_rom u_rom (
    .clk    (clk),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign in_acc      = in_valid && in_ready;
  assign settings_ok = (sample_rate_r != '0) && (duration_ms_r != '0) &&
                       (tone_one_hz_r != '0);

  always_comb begin
    case (tone_r)
      2'd0:    freq_sel = tone_one_hz_r;
      2'd1:    freq_sel = tone_two_hz_r;
      default: freq_sel = tone_three_hz_r;
    endcase
  end

  assign tone_active = (tone_r == 2'd0) || (freq_sel != '0);
  assign tone_count  = 2'd1 + {1'b0, tone_two_hz_r != '0} + {1'b0, tone_three_hz_r != '0};

  // fade ramps: rising over the first F samples, falling over the last F
  assign fade_in     = (fade_length_r != '0) && (sample_index_r < fade_length_r);
  assign fade_out    = (fade_length_r != '0) &&
                       (sample_index_r >= tone_length_r - fade_length_r);
  assign fade_div_en = fade_in || fade_out;
  assign fade_num    = fade_in ? sample_index_r
                               : tone_length_r - LEN_W'(1) - sample_index_r;

  // phase advance, both terms already below the sample rate
  assign res_sum = {1'b0, r_r} + {1'b0, fm_r};
  assign res_nxt = (res_sum >= {1'b0, sample_rate_r}) ?
                   SR_W'(res_sum - {1'b0, sample_rate_r}) : res_sum[SR_W-1:0];

  // wave position: quadrant in the top two bits, table offset below
  assign pos_full = {phase_r, {(SINE_AW + 2){1'b0}}};
  assign pos      = pos_full[SINE_AW+17:16];
  assign pos_k    = pos[SINE_AW-1:0];
  assign rom_addr = pos[SINE_AW] ? (SINE_AW'(0) - pos_k) : pos_k;

  // odd quadrant at offset zero is the peak itself
  assign wave_mag = (pos[SINE_AW] && (pos_k == '0)) ? PEAK : rom_data;
  assign wave_val = pos[SINE_AW+1] ? -$signed({2'b00, wave_mag}) : $signed({2'b00, wave_mag});

  assign sum_abs  = sum_r[17] ? 18'(-sum_r) : 18'(sum_r);
  assign mag_sat  = (div_quo > DIV_W'(PEAK)) ? PEAK : div_quo[15:0];
  assign out_go   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && settings_ok) begin
          state_nxt = in_restart ? S_LEN_MUL : S_CHECK;
        end
      end
      S_LEN_MUL: state_nxt = S_LEN_GO;
      S_LEN_GO:  state_nxt = S_LEN_WT;
      S_LEN_WT:  if (div_stat.done) state_nxt = S_FL_GO;
      S_FL_GO:   state_nxt = S_FL_WT;
      S_FL_WT:   if (div_stat.done) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = (sample_index_r >= tone_length_r) ? S_IDLE : S_RES_GO;
      S_RES_GO:  state_nxt = S_RES_WT;
      S_RES_WT:  if (div_stat.done) state_nxt = S_FRQ_GO;
      S_FRQ_GO:  state_nxt = S_FRQ_WT;
      S_FRQ_WT:  if (div_stat.done) state_nxt = S_PH_GO;
      S_PH_GO:   state_nxt = S_PH_WT;
      S_PH_WT:   if (div_stat.done) state_nxt = S_ROM;
      S_ROM:     state_nxt = S_ACC;
      S_ACC:     state_nxt = (tone_r == 2'd2) ? S_FADE_GO : S_RES_GO;
      S_FADE_GO: state_nxt = fade_div_en ? S_FADE_WT : S_MUL;
      S_FADE_WT: if (div_stat.done) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_FIN_GO;
      S_FIN_GO:  state_nxt = S_FIN_WT;
      S_FIN_WT:  if (div_stat.done) state_nxt = S_OUT;
      S_OUT:     if (out_go) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and divider launches
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = '0;
    div_req.divisor  = '0;
    div_req.rem_init = '0;
    div_req.dividend = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_LEN_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(34);
        div_req.divisor  = REM_W'(1000);
        div_req.dividend = {prod_len_r, 6'b0};
      end
      S_FL_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(25);
        div_req.divisor  = REM_W'(5);
        div_req.dividend = {tone_length_r, 1'b0, 15'b0};
      end
      S_RES_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(SR_W);
        div_req.divisor  = REM_W'(sample_rate_r);
        div_req.dividend = {residue_r[tone_r], 22'b0};
      end
      S_FRQ_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(FREQ_W);
        div_req.divisor  = REM_W'(sample_rate_r);
        div_req.dividend = {freq_sel, 23'b0};
      end
      S_PH_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(16);
        div_req.divisor  = REM_W'(sample_rate_r);
        div_req.rem_init = REM_W'(r_r);
      end
      S_FADE_GO: begin
        div_req.start    = fade_div_en;
        div_req.steps    = STEP_W'(16);
        div_req.divisor  = fade_length_r;
        div_req.rem_init = fade_num;
      end
      S_FIN_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(18);
        div_req.divisor  = REM_W'(tone_count);
        div_req.dividend = {prod_r[33:16], 22'b0};
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r   <= SR_W'(48000);
      duration_ms_r   <= DUR_W'(1000);
      tone_one_hz_r   <= FREQ_W'(1000);
      tone_two_hz_r   <= '0;
      tone_three_hz_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate_r   <= cfg_data;
        REG_DURATION_MS: duration_ms_r   <= cfg_data[DUR_W-1:0];
        REG_TONE_ONE:    tone_one_hz_r   <= cfg_data[FREQ_W-1:0];
        REG_TONE_TWO:    tone_two_hz_r   <= cfg_data[FREQ_W-1:0];
        REG_TONE_THREE:  tone_three_hz_r <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // tone state: length, fade, position and the three phase residues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      tone_length_r  <= '0;
      fade_length_r  <= '0;
      residue_r[0]   <= '0;
      residue_r[1]   <= '0;
      residue_r[2]   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // a restart with bad settings still ends the tone
          if (in_acc && !settings_ok && in_restart) begin
            sample_index_r <= '0;
            tone_length_r  <= '0;
            fade_length_r  <= '0;
          end
        end
        S_LEN_WT: begin
          if (div_stat.done) begin
            tone_length_r <= (div_quo > DIV_W'(LEN_MAX)) ? LEN_MAX : div_quo[LEN_W-1:0];
          end
        end
        S_FL_WT: begin
          if (div_stat.done) begin
            fade_length_r  <= div_quo[LEN_W-1:0];
            sample_index_r <= '0;
            residue_r[0]   <= '0;
            residue_r[1]   <= '0;
            residue_r[2]   <= '0;
          end
        end
        S_ACC: residue_r[tone_r] <= res_nxt;
        S_OUT: if (out_go) sample_index_r <= sample_index_r + LEN_W'(1);
        default: ;
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_LEN_MUL: prod_len_r <= 34'(sample_rate_r) * 34'(duration_ms_r);
      S_CHECK: begin
        tone_r <= 2'd0;
        sum_r  <= '0;
      end
      S_RES_WT: if (div_stat.done) r_r     <= div_rem[SR_W-1:0];
      S_FRQ_WT: if (div_stat.done) fm_r    <= div_rem[SR_W-1:0];
      S_PH_WT:  if (div_stat.done) phase_r <= div_quo[15:0];
      S_ACC: begin
        if (tone_active) sum_r <= sum_r + wave_val;
        tone_r <= tone_r + 2'd1;
      end
      S_FADE_GO: if (!fade_div_en) fade_r <= FADE_ONE;
      S_FADE_WT: if (div_stat.done) fade_r <= {1'b0, div_quo[15:0]};
      S_MUL: begin
        prod_r <= 34'(sum_abs[16:0]) * 34'(fade_r);
        neg_r  <= sum_r[17];
      end
      S_FIN_WT: begin
        if (div_stat.done) begin
          sample_res_r <= neg_r ? -$signed(mag_sat) : $signed(mag_sat);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_go) begin
      out_sample_r <= sample_res_r;
      out_last_r   <= (sample_index_r + LEN_W'(1)) == tone_length_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  // checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> (res_nxt < sample_rate_r))
    else $error("phase residue not reduced");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (fade_r <= FADE_ONE))
    else $error("fade above unity");

endmodule
